### rtl/plec_pkg.sv
package plec_pkg;

  // List size and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int OUT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Cells are reduced in groups of eight
  localparam int GROUP_N  = 8;
  localparam int GSEL_W   = $clog2(GROUP_N);
  localparam int NGRP     = (CAPACITY + GROUP_N - 1) / GROUP_N;
  localparam int NCELL    = NGRP * GROUP_N;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_SEARCH = 2'd3
  } plec_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } plec_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE
  } plec_state_e;

  // Broadcast to every cell
  typedef struct packed {
    logic              upd_ins;
    logic              upd_rem;
    logic [CNT_W-1:0]  at;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] val;
  } plec_op_t;

  // Registered summary of one group of cells
  typedef struct packed {
    logic              hit;
    logic [GSEL_W-1:0] first;
    logic [DATA_W-1:0] data;
  } plec_grp_t;

endpackage

### rtl/positional_list_engine_top.sv
// A request steps through accept, cell scan and merge; its result is registered
//   when the merge commits, and no new request is taken until then;
//   the merge step holds while an earlier result is still stalled.
// The cell row shifts on insert/remove in the merge cycle, so every request
//   costs the same regardless of position or list size.
// Reset: rst_ni clears the entry count, the control state and out_valid_o;
//   cell contents stay undefined until written.
module positional_list_engine_top import plec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic              at_end_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [DATA_W-1:0] data_out_o,
  output logic [OUT_W-1:0]  index_out_o,
  output logic [OUT_W-1:0]  size_out_o
);

  // Control state
  plec_state_e      state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;

  // Held request
  plec_mode_e        mode_q;
  logic              at_end_q;
  logic              beyond_q;   // position at or beyond the size
  logic [CNT_W-1:0]  at_q;
  logic [DATA_W-1:0] val_q;

  // Result register
  plec_status_e      status_q, status_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [OUT_W-1:0]  index_q, index_d;
  logic [OUT_W-1:0]  size_q, size_d;

  logic accept, commit, empty, full, beyond, hit;
  logic [CNT_W-1:0] at_acc, first_idx;
  logic [DATA_W-1:0] sel_data;

  plec_op_t op;

  logic [NCELL-1:0]             match_w;
  logic [NCELL-1:0][DATA_W-1:0] rd_w;
  logic [NCELL-1:0][DATA_W-1:0] entry_w;
  plec_grp_t [NGRP-1:0]         grp_w;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign beyond     = CMP_W'(position_i) >= CMP_W'(count_q);

  // Target slot: insert appends at the size, remove/read fall back to the last entry
  always_comb begin
    if (mode_i == MODE_INSERT) begin
      at_acc = (at_end_i || beyond) ? count_q : CNT_W'(position_i);
    end else begin
      at_acc = (at_end_i || beyond) ? (count_q - CNT_W'(1)) : CNT_W'(position_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= plec_mode_e'(mode_i);
      at_end_q <= at_end_i;
      beyond_q <= beyond;
      at_q     <= at_acc;
      val_q    <= value_i;
    end
  end

  // Broadcast to the cell row; shifts only fire on commit
  always_comb begin
    op.upd_ins = commit && (mode_q == MODE_INSERT) && !full;
    op.upd_rem = commit && (mode_q == MODE_REMOVE) && !empty;
    op.at      = at_q;
    op.cnt     = count_q;
    op.val     = val_q;
  end

  // Cell row
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i < CAPACITY) begin : g_real
      logic [DATA_W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = entry_w[i+1];
      end
      plec_cell u_cell (
        .clk_i     (clk_i),
        .idx_i     (CNT_W'(i)),
        .op_i      (op),
        .left_i    (left_w),
        .right_i   (right_w),
        .entry_o   (entry_w[i]),
        .match_o   (match_w[i]),
        .rd_data_o (rd_w[i])
      );
    end else begin : g_pad
      assign entry_w[i] = '0;
      assign match_w[i] = 1'b0;
      assign rd_w[i]    = '0;
    end
  end

  // Group reducers
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    plec_group u_group (
      .clk_i   (clk_i),
      .match_i (match_w[g*GROUP_N +: GROUP_N]),
      .data_i  (rd_w[g*GROUP_N +: GROUP_N]),
      .grp_o   (grp_w[g])
    );
  end

  // Merge the group summaries: lowest hit wins, data is OR'd
  always_comb begin
    hit       = 1'b0;
    first_idx = '0;
    sel_data  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_w[g].hit) begin
        hit       = 1'b1;
        first_idx = CNT_W'(g * GROUP_N) | CNT_W'(grp_w[g].first);
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      sel_data = sel_data | grp_w[g].data;
    end
  end

  // Sequencer and result formation
  always_comb begin
    state_d  = state_q;
    commit   = 1'b0;
    count_d  = count_q;
    status_d = ST_OK;
    data_d   = '0;
    index_d  = OUT_W'(count_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SCAN;
      end
      S_SCAN: begin
        state_d = S_MERGE;
      end
      S_MERGE: begin
        // hold until the result slot is free
        if (!out_valid_q || !out_stall_i) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    unique case (mode_q)
      MODE_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          data_d  = sel_data;
          count_d = count_q - CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!at_end_q && beyond_q) begin
          status_d = ST_MISS;
        end else begin
          data_d = sel_data;
        end
      end
      MODE_SEARCH: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (hit) begin
          index_d = OUT_W'(first_idx);
        end else begin
          status_d = ST_MISS;
        end
      end
      default: status_d = ST_OK;
    endcase

    size_d = OUT_W'(count_d);
    if (!commit) count_d = count_q;

    out_valid_d = commit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load on commit only, so a stalled transfer holds
  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      data_q   <= data_d;
      index_q  <= index_d;
      size_q   <= size_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign index_out_o = index_q;
  assign size_out_o  = size_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_remove_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && mode_q == MODE_REMOVE && !empty |-> at_q < count_q)
    else $error("remove target outside the list");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.upd_ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.upd_rem |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not shrink the list");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

### rtl/plec_cell.sv
module plec_cell import plec_pkg::*; (
  input  logic              clk_i,
  input  logic [CNT_W-1:0]  idx_i,
  input  plec_op_t          op_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] entry_o,
  output logic              match_o,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [CNT_W-1:0]  idx_nx;

  assign idx_nx = idx_i + CNT_W'(1);

  always_comb begin
    entry_d = entry_q;
    if (op_i.upd_ins) begin
      if (idx_i == op_i.at) begin
        entry_d = op_i.val;
      end else if (idx_i > op_i.at && idx_i <= op_i.cnt) begin
        entry_d = left_i;  // move back by one
      end
    end else if (op_i.upd_rem) begin
      if (idx_i >= op_i.at && idx_nx < op_i.cnt) begin
        entry_d = right_i; // close the gap
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign match_o   = (entry_q == op_i.val) && (idx_i < op_i.cnt);
  assign rd_data_o = (idx_i == op_i.at) ? entry_q : '0;

endmodule

### rtl/plec_group.sv
module plec_group import plec_pkg::*; (
  input  logic                           clk_i,
  input  logic [GROUP_N-1:0]             match_i,
  input  logic [GROUP_N-1:0][DATA_W-1:0] data_i,
  output plec_grp_t                      grp_o
);

  plec_grp_t grp_q, grp_d;

  always_comb begin
    grp_d       = '0;
    grp_d.hit   = |match_i;
    // descending walk leaves the lowest match selected
    for (int k = GROUP_N - 1; k >= 0; k--) begin
      if (match_i[k]) begin
        grp_d.first = GSEL_W'(k);
      end
    end
    for (int k = 0; k < GROUP_N; k++) begin
      grp_d.data = grp_d.data | data_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

### verif/tb_positional_list_engine_top.sv
`timescale 1ns / 1ps

module tb_positional_list_engine_top;
  import plec_pkg::*;

  // One expected reply, kept at the widths of the output ports
  typedef struct packed {
    plec_status_e      status;
    logic [DATA_W-1:0] data;
    logic [OUT_W-1:0]  index;
    logic [OUT_W-1:0]  size;
  } list_result_t;

  // Shadow copy of the list: predict the reply to every accepted request and
  // hold the replies still owed by the block, oldest first.
  class list_mirror;
    logic [DATA_W-1:0] cells [CAPACITY];
    int                fill = 0;
    list_result_t      owed_results [$];
    int                mismatches = 0;

    task report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    function void note_request(input plec_mode_e mode, input logic [POS_W-1:0] pos,
                               input logic at_end, input logic [DATA_W-1:0] val);
      list_result_t res;
      int           prior;
      int           slot;
      int           found;
      int           i;
      prior      = fill;
      found      = prior;
      res.status = ST_OK;
      res.data   = '0;
      case (mode)
        MODE_INSERT: begin
          if (prior >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            // a position at or past the end appends
            slot = (at_end || int'(pos) >= prior) ? prior : int'(pos);
            for (i = prior; i > slot; i--) cells[i] = cells[i-1];
            cells[slot] = val;
            fill++;
          end
        end
        MODE_REMOVE: begin
          if (prior == 0) begin
            res.status = ST_EMPTY;
          end else begin
            slot     = (at_end || int'(pos) >= prior) ? prior - 1 : int'(pos);
            res.data = cells[slot];
            for (i = slot; i + 1 < prior; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        MODE_READ: begin
          if (prior == 0) res.status = ST_EMPTY;
          else if (at_end) res.data = cells[prior-1];
          else if (int'(pos) >= prior) res.status = ST_MISS;
          else res.data = cells[pos];
        end
        default: begin
          if (prior == 0) begin
            res.status = ST_EMPTY;
          end else begin
            // lowest matching index wins
            res.status = ST_MISS;
            for (i = 0; i < prior && res.status == ST_MISS; i++) begin
              if (cells[i] == val) begin
                res.status = ST_OK;
                found      = i;
              end
            end
          end
        end
      endcase
      res.index = OUT_W'(found);
      res.size  = OUT_W'(fill);
      owed_results.push_back(res);
    endfunction

    task check_result(input logic [1:0] status, input logic [DATA_W-1:0] data,
                      input logic [OUT_W-1:0] index, input logic [OUT_W-1:0] size);
      list_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("reply with nothing owed: status %0d size %0d",
                                  status, size));
        return;
      end
      want = owed_results.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (data !== want.data)
        report_mismatch($sformatf("data_out %h, want %h", data, want.data));
      if (index !== want.index)
        report_mismatch($sformatf("index_out %0d, want %0d", index, want.index));
      if (size !== want.size)
        report_mismatch($sformatf("size_out %0d, want %0d", size, want.size));
    endtask
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [1:0]        mode_i      = MODE_INSERT;
  logic [POS_W-1:0]  position_i  = '0;
  logic              at_end_i    = 1'b0;
  logic [DATA_W-1:0] value_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [DATA_W-1:0] data_out_o;
  logic [OUT_W-1:0]  index_out_o;
  logic [OUT_W-1:0]  size_out_o;

  // Idle rates in percent: gaps between requests, stalls on the reply side
  int request_gap_pct = 27;
  int reply_stall_pct = 45;

  list_mirror mirror;

  positional_list_engine_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .position_i  (position_i),
    .at_end_i    (at_end_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .index_out_o (index_out_o),
    .size_out_o  (size_out_o)
  );

  always #6 clk_i = ~clk_i;

  // Stall the reply side at random, one fresh decision per cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < reply_stall_pct);
  end

  // Watch both channels at the edge. Check the reply before noting the
  // request: a request accepted at this edge cannot have answered yet.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        mirror.check_result(status_o, data_out_o, index_out_o, size_out_o);
      if (in_valid_i && !in_stall_o)
        mirror.note_request(plec_mode_e'(mode_i), position_i, at_end_i, value_i);
    end
  end

  // Offer one request and hold it until the transfer. Leave valid high on
  // return so back-to-back requests keep it up without a dip.
  task send_request(input plec_mode_e mode, input logic [POS_W-1:0] pos,
                    input logic at_end, input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < request_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    position_i <= pos;
    at_end_i   <= at_end;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Small values two times in five so that searches hit and duplicates occur,
  // some extremes, the rest anywhere in the 32-bit range.
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return DATA_W'($urandom_range(15)) - DATA_W'(3);
    if (r < 50) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // Mostly inside or just past the list; sometimes anywhere the port allows
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return POS_W'($urandom_range(mirror.fill + 1));
    if (r < 80) return POS_W'($urandom_range(CAPACITY));
    return POS_W'($urandom_range(127));
  endfunction

  // One random request, weighted towards growing or shrinking the list
  task send_random_request(input int insert_pct, input int remove_pct);
    int unsigned       r;
    plec_mode_e        mode;
    logic [DATA_W-1:0] val;
    r = $urandom_range(99);
    if (r < insert_pct) mode = MODE_INSERT;
    else if (r < insert_pct + remove_pct) mode = MODE_REMOVE;
    else if (r[0]) mode = MODE_READ;
    else mode = MODE_SEARCH;
    val = pick_value();
    // search for a value known to be present about half the time
    if (mode == MODE_SEARCH && mirror.fill > 0 && $urandom_range(1))
      val = mirror.cells[$urandom_range(mirror.fill - 1)];
    send_request(mode, pick_position(), ($urandom_range(4) == 0), val);
  endtask

  // Grow the list towards full, churn, then drain it towards empty
  task run_random_phase();
    repeat (105) send_random_request(75, 10);
    repeat (70)  send_random_request(35, 30);
    repeat (105) send_random_request(10, 75);
  endtask

  initial begin
    mirror = new;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: remove, read and search report empty
    send_request(MODE_REMOVE, 7'd0,   1'b0, '0);
    send_request(MODE_READ,   7'd0,   1'b0, '0);
    send_request(MODE_SEARCH, 7'd0,   1'b0, 32'd9);
    // Build [min, 0, max, 0, -1, 5]: append past the end, at the front,
    // at exactly the size, by the end flag, and in the middle
    send_request(MODE_INSERT, 7'd64,  1'b0, 32'h7fff_ffff);
    send_request(MODE_INSERT, 7'd0,   1'b0, 32'h8000_0000);
    send_request(MODE_INSERT, 7'd2,   1'b0, 32'h0000_0000);
    send_request(MODE_INSERT, 7'd0,   1'b1, 32'hffff_ffff);
    send_request(MODE_INSERT, 7'd1,   1'b0, 32'h0000_0000);
    send_request(MODE_INSERT, 7'd127, 1'b1, 32'd5);
    // Search: duplicate takes the lowest index, a miss, the front entry
    send_request(MODE_SEARCH, 7'd0,   1'b0, 32'h0000_0000);
    send_request(MODE_SEARCH, 7'd0,   1'b0, 32'd12345);
    send_request(MODE_SEARCH, 7'd3,   1'b1, 32'h8000_0000);
    // Read: end flag, position equal to size, far out of range, middle, far with end flag
    send_request(MODE_READ,   7'd0,   1'b1, '0);
    send_request(MODE_READ,   7'd6,   1'b0, '0);
    send_request(MODE_READ,   7'd127, 1'b0, '0);
    send_request(MODE_READ,   7'd2,   1'b0, '0);
    send_request(MODE_READ,   7'd127, 1'b1, '0);
    // Remove: front, middle, end flag, past the end, then drain
    send_request(MODE_REMOVE, 7'd0,   1'b0, '0);
    send_request(MODE_REMOVE, 7'd2,   1'b0, '0);
    send_request(MODE_REMOVE, 7'd0,   1'b1, '0);
    send_request(MODE_REMOVE, 7'd100, 1'b0, '1);
    send_request(MODE_REMOVE, 7'd1,   1'b0, '0);
    send_request(MODE_REMOVE, 7'd0,   1'b0, '0);
    send_request(MODE_REMOVE, 7'd0,   1'b1, '0);

    run_random_phase();
    // Swap the idle rates, then run without idling at all
    request_gap_pct = 45;
    reply_stall_pct = 27;
    run_random_phase();
    request_gap_pct = 0;
    reply_stall_pct = 0;
    run_random_phase();

    // Drop valid, wait for every owed reply, then allow for stray ones
    in_valid_i <= 1'b0;
    while (mirror.owed_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mirror.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/plec_pkg.sv
rtl/plec_cell.sv
rtl/plec_group.sv
rtl/positional_list_engine_top.sv
verif/tb_positional_list_engine_top.sv
